### hdl/crl_pkg.sv
// shared types and constants for the chat text run limiter
package crl_pkg;

  // counter width default and configuration register widths
  localparam int COUNT_BITS_DEF = 8;
  localparam int LIMIT_W        = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_RUN_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TOTAL_LIMIT = 2'd2;

  // register values after reset
  localparam logic [LIMIT_W-1:0] SPACE_LIMIT_RST      = 8'd10;
  localparam logic [LIMIT_W-1:0] CODE_RUN_LIMIT_RST   = 8'd4;
  localparam logic [LIMIT_W-1:0] CODE_TOTAL_LIMIT_RST = 8'd20;

  // character codes
  localparam logic [7:0] CTRL_MAX   = 8'h1F;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_TICK  = 8'h60;
  localparam logic [7:0] CHAR_BLANK = 8'h20;

  // input word
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_keep;
    logic       out_last;
  } out_word_t;

  // current limit settings
  typedef struct packed {
    logic [LIMIT_W-1:0] space_limit;
    logic [LIMIT_W-1:0] code_run_limit;
    logic [LIMIT_W-1:0] code_total_limit;
  } cfg_t;

endpackage

### hdl/crl_cfg_regs.sv
// limit registers written through the configuration port
module crl_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [crl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crl_pkg::CFG_DATA_W-1:0] cfg_data,
  output crl_pkg::cfg_t                 cfg
);
  import crl_pkg::*;

  cfg_t cfg_next;

  // decode the write, unknown indexes leave everything alone
  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SPACE_LIMIT:      cfg_next.space_limit      = cfg_data;
        REG_CODE_RUN_LIMIT:   cfg_next.code_run_limit   = cfg_data;
        REG_CODE_TOTAL_LIMIT: cfg_next.code_total_limit = cfg_data;
        default:              cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.space_limit      <= SPACE_LIMIT_RST;
      cfg.code_run_limit   <= CODE_RUN_LIMIT_RST;
      cfg.code_total_limit <= CODE_TOTAL_LIMIT_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

### hdl/crl_filter.sv
// run counters, pair tracking and keep decision for one byte
module crl_filter #(
  parameter int COUNT_BITS = crl_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  crl_pkg::in_word_t  in_word,
  input  crl_pkg::cfg_t      cfg,
  output crl_pkg::out_word_t res
);
  import crl_pkg::*;

  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] blank_run, blank_run_next;
  logic [COUNT_BITS-1:0] marker_run, marker_run_next;
  logic [COUNT_BITS-1:0] marker_total, marker_total_next;
  logic                  pair_pending, pair_pending_next;
  logic                  pair_kept, pair_kept_next;

  logic                  is_ctrl, is_marker, is_blank;
  logic [COUNT_BITS-1:0] br_upd, mr_upd, mt_upd;
  logic                  keep_new, keep;

  // classify the byte
  assign is_ctrl   = (in_word.in_char <= CTRL_MAX);
  assign is_marker = (in_word.in_char == CHAR_TILDE) || (in_word.in_char == CHAR_TICK);
  assign is_blank  = (in_word.in_char == CHAR_BLANK);

  // saturating counter updates for a fresh byte
  always_comb begin
    br_upd = blank_run;
    mr_upd = marker_run;
    mt_upd = marker_total;
    if (is_marker || is_blank) begin
      br_upd = (blank_run == CNT_MAX) ? blank_run : blank_run + 1'b1;
      if (is_marker) begin
        mr_upd = (marker_run == CNT_MAX) ? marker_run : marker_run + 1'b1;
        mt_upd = (marker_total == CNT_MAX) ? marker_total : marker_total + 1'b1;
      end
    end else begin
      br_upd = '0;
      mr_upd = '0;
    end
  end

  // limit compares against the updated counts
  assign keep_new = (CMP_W'(br_upd) < CMP_W'(cfg.space_limit)) &&
                    (CMP_W'(mr_upd) < CMP_W'(cfg.code_run_limit)) &&
                    (!is_marker || (CMP_W'(mt_upd) < CMP_W'(cfg.code_total_limit)));

  // next state and keep bit
  always_comb begin
    blank_run_next    = blank_run;
    marker_run_next   = marker_run;
    marker_total_next = marker_total;
    pair_pending_next = pair_pending;
    pair_kept_next    = pair_kept;
    keep              = 1'b0;
    if (!is_ctrl) begin
      if (pair_pending) begin
        keep              = pair_kept;
        pair_pending_next = 1'b0;
        pair_kept_next    = 1'b0;
      end else begin
        blank_run_next    = br_upd;
        marker_run_next   = mr_upd;
        marker_total_next = mt_upd;
        keep              = keep_new;
        if (is_marker) begin
          pair_pending_next = 1'b1;
          pair_kept_next    = keep_new;
        end
      end
    end
    // end of message clears everything
    if (in_word.in_last) begin
      blank_run_next    = '0;
      marker_run_next   = '0;
      marker_total_next = '0;
      pair_pending_next = 1'b0;
      pair_kept_next    = 1'b0;
    end
  end

  assign res.out_char = in_word.in_char;
  assign res.out_keep = keep;
  assign res.out_last = in_word.in_last;

  // message state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_run    <= '0;
      marker_run   <= '0;
      marker_total <= '0;
      pair_pending <= 1'b0;
      pair_kept    <= 1'b0;
    end else if (step) begin
      blank_run    <= blank_run_next;
      marker_run   <= marker_run_next;
      marker_total <= marker_total_next;
      pair_pending <= pair_pending_next;
      pair_kept    <= pair_kept_next;
    end
  end

  // a last word leaves the message state cleared
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && in_word.in_last |=> blank_run == '0 && marker_run == '0 &&
                                marker_total == '0 && !pair_pending)
    else $error("message state not cleared after last word");

  // a pair decision only exists while a pair is open
  a_kept_needs_pending: assert property (@(posedge clk) disable iff (rst)
    !pair_pending |-> !pair_kept)
    else $error("pair_kept set with no open pair");

  // every marker also counts toward the blank run
  a_marker_in_blank: assert property (@(posedge clk) disable iff (rst)
    marker_run <= blank_run)
    else $error("marker run exceeds blank run");

  // a marker run never exceeds the message marker total
  a_run_in_total: assert property (@(posedge clk) disable iff (rst)
    marker_run <= marker_total)
    else $error("marker run exceeds marker total");

endmodule

### hdl/crl_out_stage.sv
// result register between the filter and the output channel
module crl_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  crl_pkg::out_word_t res,
  output logic               out_valid,
  input  logic               out_stall,
  output crl_pkg::out_word_t out_word,
  output logic               full_stalled
);
  import crl_pkg::*;

  logic out_valid_next;

  // hold while stalled, refill or drain otherwise
  assign full_stalled   = out_valid && out_stall;
  assign out_valid_next = load || full_stalled;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res;
    end
  end

endmodule

### hdl/chat_text_run_limiter_top.sv
// top level of the chat text run limiter
// Filters a chat message one byte per word and returns every byte with a keep
// flag: control bytes are dropped, runs of blanks and color markers are
// limited, and a marker with the byte after it is kept or dropped as a pair.
// Each input word gives exactly one result word, in the cycle after it is
// accepted; a new word can be taken every cycle unless stalled, since the run
// counters are updated and compared combinationally and one result register
// holds the word. Input stall follows output stall only while that result
// register is full. Limits must be set through cfg_we/cfg_index/cfg_data
// while no message word is in flight; the block itself does not enforce this.
module chat_text_run_limiter_top #(
  parameter int COUNT_BITS = crl_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  crl_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output crl_pkg::out_word_t             out_word,
  input  logic                           cfg_we,
  input  logic [crl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crl_pkg::*;

  cfg_t      cfg;
  out_word_t res;
  logic      accept;
  logic      full_stalled;

  assign in_stall = full_stalled;
  assign accept   = in_valid && !in_stall;

  // limit registers
  crl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // counters and keep decision
  crl_filter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_filter (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .in_word (in_word),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  crl_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .res          (res),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .full_stalled (full_stalled)
  );

  // a control byte always comes out dropped
  a_ctrl_dropped: assert property (@(posedge clk) disable iff (rst)
    accept && (in_word.in_char <= CTRL_MAX) |=> out_valid && !out_word.out_keep)
    else $error("control byte kept");

  // an accepted word shows up as a result in the next cycle, unchanged
  a_word_through: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && out_word.out_char == $past(in_word.in_char) &&
               out_word.out_last == $past(in_word.in_last))
    else $error("accepted word not passed to result register");

  // input is never stalled while the result register can take a word
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid || !out_stall |-> !in_stall)
    else $error("input stalled with free result register");

endmodule
